// File: sv/tlpt_pkg.sv
// Shared types and constants for the two-level page table engine.
// No dependencies.
package tlpt_pkg;

	localparam logic [1:0] CMD_MAP = 2'd0;
	localparam logic [1:0] CMD_UNMAP = 2'd1;
	localparam logic [1:0] CMD_XLATE = 2'd2;
	localparam logic [1:0] CMD_NOP = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_ALIGN = 3'd1;
	localparam logic [2:0] ST_BUSY = 3'd2;
	localparam logic [2:0] ST_DIR_EMPTY = 3'd3;
	localparam logic [2:0] ST_NO_TABLE = 3'd4;

	localparam int DIR_ENTRIES = 1024;
	localparam int PAGES_PER_TABLE = 1024;
	localparam int DIR_W = 10;
	localparam int TAB_W = 10;

	typedef struct packed {
		logic [1:0] command;
		logic [31:0] phys_addr;
		logic [31:0] virt_addr;
		logic [11:0] attributes;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [31:0] translated_addr;
	} rsp_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_DIR_RD,
		S_DECIDE,
		S_CLEAR,
		S_ENT_RD,
		S_ENT_CHK,
		S_OCC_CHK,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic init_step;
		logic load;
		logic dir_rd;
		logic ent_rd;
		logic alloc;
		logic clr_step;
		logic ent_chk;
		logic ent_write;
		logic ent_zero;
		logic occ_check;
		logic finish;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] command;
		logic misaligned;
		logic dir_valid;
		logic slot_free;
		logic init_last;
		logic clr_last;
		logic entry_nz;
	} sts_t;

endpackage

// File: sv/tlpt_ctrl.sv
// Controller state machine for the page table engine.
// Depends on tlpt_pkg.
module tlpt_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input tlpt_pkg::sts_t sts,
	output tlpt_pkg::ctl_t ctl
);
	tlpt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= tlpt_pkg::S_INIT;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tlpt_pkg::S_INIT: if (sts.init_last) state_d = tlpt_pkg::S_IDLE;
			tlpt_pkg::S_IDLE: if (start) state_d = tlpt_pkg::S_DIR_RD;
			tlpt_pkg::S_DIR_RD: state_d = tlpt_pkg::S_DECIDE;
			tlpt_pkg::S_DECIDE: begin
				priority if (sts.command == tlpt_pkg::CMD_MAP) begin
					if (sts.misaligned) state_d = tlpt_pkg::S_DONE;
					else if (sts.dir_valid) state_d = tlpt_pkg::S_ENT_RD;
					else if (sts.slot_free) state_d = tlpt_pkg::S_CLEAR;
					else state_d = tlpt_pkg::S_DONE;
				end else if (sts.command == tlpt_pkg::CMD_UNMAP) begin
					if (sts.misaligned || !sts.dir_valid) state_d = tlpt_pkg::S_DONE;
					else state_d = tlpt_pkg::S_ENT_RD;
				end else if (sts.command == tlpt_pkg::CMD_XLATE) begin
					if (!sts.dir_valid) state_d = tlpt_pkg::S_DONE;
					else state_d = tlpt_pkg::S_ENT_RD;
				end else state_d = tlpt_pkg::S_DONE;
			end
			tlpt_pkg::S_CLEAR: if (sts.clr_last) state_d = tlpt_pkg::S_DONE;
			tlpt_pkg::S_ENT_RD: state_d = tlpt_pkg::S_ENT_CHK;
			tlpt_pkg::S_ENT_CHK:
				state_d = (sts.command == tlpt_pkg::CMD_UNMAP) ? tlpt_pkg::S_OCC_CHK
					: tlpt_pkg::S_DONE;
			tlpt_pkg::S_OCC_CHK: state_d = tlpt_pkg::S_DONE;
			tlpt_pkg::S_DONE: state_d = tlpt_pkg::S_IDLE;
			default: state_d = tlpt_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		busy = (state_q != tlpt_pkg::S_IDLE);
		unique case (state_q)
			tlpt_pkg::S_INIT: ctl.init_step = 1'b1;
			tlpt_pkg::S_IDLE: ctl.load = start;
			tlpt_pkg::S_DIR_RD: ctl.dir_rd = 1'b1;
			tlpt_pkg::S_DECIDE: begin
				ctl.ent_rd = 1'b1;
				ctl.alloc = (sts.command == tlpt_pkg::CMD_MAP) && !sts.misaligned
					&& !sts.dir_valid && sts.slot_free;
			end
			tlpt_pkg::S_CLEAR: ctl.clr_step = 1'b1;
			tlpt_pkg::S_ENT_RD: ;
			tlpt_pkg::S_ENT_CHK: begin
				ctl.ent_chk = 1'b1;
				ctl.ent_write = (sts.command == tlpt_pkg::CMD_MAP) && !sts.entry_nz;
				ctl.ent_zero = (sts.command == tlpt_pkg::CMD_UNMAP) && sts.entry_nz;
			end
			tlpt_pkg::S_OCC_CHK: ctl.occ_check = 1'b1;
			tlpt_pkg::S_DONE: ctl.finish = 1'b1;
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_clear_from_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tlpt_pkg::S_CLEAR && $past(state_q) != tlpt_pkg::S_CLEAR)
		|-> $past(state_q) == tlpt_pkg::S_DECIDE)
		else $error("clear entered without allocation");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tlpt_pkg::S_DONE |=> state_q == tlpt_pkg::S_IDLE)
		else $error("done not followed by idle");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");
`endif
endmodule

// File: sv/tlpt_dpath.sv
// Datapath: directory, slot pool, page entry memory and result register.
// Depends on tlpt_pkg.
module tlpt_dpath #(
	parameter int TABLE_SLOTS = 16
) (
	input logic clk,
	input logic arst_n,
	input tlpt_pkg::req_t req,
	input tlpt_pkg::ctl_t ctl,
	output tlpt_pkg::sts_t sts,
	output logic done,
	output tlpt_pkg::rsp_t rsp
);
	localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int AW = SW + tlpt_pkg::TAB_W;
	localparam int OW = tlpt_pkg::TAB_W + 1;

	tlpt_pkg::req_t req_q;
	// directory entry: valid bit on top, slot number below
	logic [SW:0] dir_mem [tlpt_pkg::DIR_ENTRIES];
	logic [SW:0] dir_s1;
	logic [SW-1:0] slot_q;
	logic [TABLE_SLOTS-1:0] used_q;
	logic [OW-1:0] occ_q [TABLE_SLOTS];
	logic [31:0] ent_mem [TABLE_SLOTS * tlpt_pkg::PAGES_PER_TABLE];
	logic [31:0] ent_q;
	logic [tlpt_pkg::TAB_W-1:0] clr_q;
	logic [tlpt_pkg::DIR_W-1:0] init_q;
	logic [2:0] status_q;
	logic [31:0] xaddr_q;
	logic done_q;

	logic [tlpt_pkg::DIR_W-1:0] didx;
	logic [tlpt_pkg::TAB_W-1:0] tidx;
	logic [SW-1:0] free_slot;
	logic any_free;
	logic [31:0] new_ent;
	logic [31:0] clr_ent;
	logic [OW-1:0] occ_cur;

	assign didx = req_q.virt_addr[31:22];
	assign tidx = req_q.virt_addr[21:12];
	assign new_ent = {req_q.phys_addr[31:12], req_q.attributes};
	// the clear pass drops the new entry in as it goes by
	assign clr_ent = (clr_q == tidx) ? new_ent : 32'd0;
	assign occ_cur = occ_q[slot_q];

	always_comb begin
		free_slot = '0;
		any_free = 1'b0;
		for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_slot = SW'(i);
				any_free = 1'b1;
			end
		end
	end

	assign sts.command = req_q.command;
	assign sts.misaligned = (req_q.virt_addr[11:0] != 12'd0)
		|| ((req_q.command == tlpt_pkg::CMD_MAP) && (req_q.phys_addr[11:0] != 12'd0));
	assign sts.dir_valid = dir_s1[SW];
	assign sts.slot_free = any_free;
	assign sts.init_last = (init_q == '1);
	assign sts.clr_last = (clr_q == '1);
	assign sts.entry_nz = (ent_q != 32'd0);

	always_ff @(posedge clk) begin
		if (ctl.load) req_q <= req;
		if (ctl.dir_rd) dir_s1 <= dir_mem[didx];
		if (ctl.init_step) dir_mem[init_q] <= '0;
		else if (ctl.alloc) dir_mem[didx] <= {1'b1, free_slot};
		else if (ctl.occ_check && occ_cur == '0) dir_mem[didx] <= '0;
		if (ctl.alloc) slot_q <= free_slot;
		else if (ctl.ent_rd) slot_q <= dir_s1[SW-1:0];
		if (ctl.clr_step) ent_mem[{slot_q, clr_q}] <= clr_ent;
		else if (ctl.ent_write) ent_mem[{slot_q, tidx}] <= new_ent;
		else if (ctl.ent_zero) ent_mem[{slot_q, tidx}] <= 32'd0;
		ent_q <= ent_mem[AW'({slot_q, tidx})];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			for (int i = 0; i < TABLE_SLOTS; i++) occ_q[i] <= '0;
			clr_q <= '0;
			init_q <= '0;
			status_q <= tlpt_pkg::ST_OK;
			xaddr_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.finish;
			if (ctl.init_step) init_q <= init_q + 1'b1;
			if (ctl.load) begin
				status_q <= tlpt_pkg::ST_OK;
				xaddr_q <= '0;
			end
			if (ctl.ent_rd) begin
				unique case (req_q.command)
					tlpt_pkg::CMD_MAP:
						if (sts.misaligned) status_q <= tlpt_pkg::ST_ALIGN;
						else if (!sts.dir_valid && !any_free)
							status_q <= tlpt_pkg::ST_NO_TABLE;
					tlpt_pkg::CMD_UNMAP:
						if (sts.misaligned) status_q <= tlpt_pkg::ST_ALIGN;
						else if (!sts.dir_valid) status_q <= tlpt_pkg::ST_DIR_EMPTY;
					tlpt_pkg::CMD_XLATE:
						if (!sts.dir_valid) status_q <= tlpt_pkg::ST_DIR_EMPTY;
					default: ;
				endcase
			end
			if (ctl.alloc) begin
				used_q[free_slot] <= 1'b1;
				occ_q[free_slot] <= '0;
				clr_q <= '0;
			end
			if (ctl.clr_step) begin
				clr_q <= clr_q + 1'b1;
				if (sts.clr_last && new_ent != 32'd0) occ_q[slot_q] <= occ_cur + 1'b1;
			end
			if (ctl.ent_write && new_ent != 32'd0)
				occ_q[slot_q] <= occ_cur + 1'b1;
			if (ctl.ent_chk && req_q.command == tlpt_pkg::CMD_MAP && sts.entry_nz)
				status_q <= tlpt_pkg::ST_BUSY;
			if (ctl.ent_zero && occ_cur != '0) occ_q[slot_q] <= occ_cur - 1'b1;
			if (ctl.occ_check && occ_cur == '0) used_q[slot_q] <= 1'b0;
			if (ctl.ent_chk && req_q.command == tlpt_pkg::CMD_XLATE)
				xaddr_q <= {ent_q[31:12], req_q.virt_addr[11:0]};
		end
	end

	assign done = done_q;
	assign rsp.status = status_q;
	assign rsp.translated_addr = xaddr_q;

`ifndef SYNTHESIS
	a_no_alloc_used: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.alloc |-> !used_q[free_slot])
		else $error("allocating a used slot");
	a_alloc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.alloc |=> clr_q == '0)
		else $error("clear counter not reset");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");
`endif
endmodule

// File: sv/two_level_page_table_engine_core.sv
// Top level of the two-level page table engine.
// Depends on tlpt_pkg, tlpt_ctrl, tlpt_dpath.
// One command word is taken when start is high and busy low; its result word appears
// on rsp with done high for one cycle, which the receiver cannot stall. After reset,
// busy stays high while the directory is cleared. Translate, unmap and a map into an
// existing table step through directory read, decide, entry read and entry check, with
// an occupancy check after an unmap; errors found at decide skip to done. A map that
// allocates a table clears the slot one entry a cycle instead of the entry read.
module two_level_page_table_engine_core #(
	parameter int TABLE_SLOTS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input tlpt_pkg::req_t req,
	output logic done,
	output tlpt_pkg::rsp_t rsp
);
	tlpt_pkg::ctl_t ctl;
	tlpt_pkg::sts_t sts;

	tlpt_ctrl u_ctrl (.clk, .arst_n, .start, .busy, .sts, .ctl);
	tlpt_dpath #(.TABLE_SLOTS(TABLE_SLOTS)) u_dpath (
		.clk, .arst_n, .req, .ctl, .sts, .done, .rsp);
endmodule
